// ===== rtl/hpa_pkg.sv =====
// Shared types and constants of the handle pool allocator.
`default_nettype none

package hpa_pkg;

   localparam int POOL_SIZE = 256;
   localparam int IDX_W     = $clog2(POOL_SIZE);
   localparam int CNT_W     = $clog2(POOL_SIZE + 1);
   localparam int SUM_W     = CNT_W + 1;
   localparam int HANDLE_W  = 8;
   localparam int CMP_W     = (HANDLE_W > CNT_W) ? HANDLE_W : CNT_W;

   typedef enum logic [1:0] {
      OP_ALLOC = 2'd0,
      OP_TRY   = 2'd1,
      OP_FREE  = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STAT_OK        = 2'd0,
      STAT_EMPTY     = 2'd1,
      STAT_NOT_ALLOC = 2'd2,
      STAT_EXHAUSTED = 2'd3
   } status_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_EXEC = 1'b1
   } state_type;

   typedef struct packed {
      logic             rd_en;
      logic [IDX_W-1:0] rd_addr;
      logic             wr_en;
      logic [IDX_W-1:0] wr_addr;
      logic [IDX_W-1:0] wr_data;
   } queue_port_type;

   typedef struct packed {
      logic             rd_en;
      logic [IDX_W-1:0] rd_addr;
      logic             wr_en;
      logic [IDX_W-1:0] wr_addr;
      logic             wr_data;
   } map_port_type;

   typedef struct packed {
      logic [HANDLE_W-1:0] handle;
      status_type          status;
   } result_type;

endpackage

`default_nettype wire

// ===== rtl/hpa_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module hpa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/hpa_ctrl.sv =====
// Request sequencer: reads the queue and map, then updates pointers, counters and memories.
`default_nettype none

module hpa_ctrl
(
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire hpa_pkg::op_type               req_op,
   input  wire logic [hpa_pkg::HANDLE_W-1:0]  req_handle,
   input  wire logic                          out_free,
   output logic                               rsp_load,
   output hpa_pkg::result_type                rsp_result,
   output hpa_pkg::queue_port_type            queue_port,
   input  wire logic [hpa_pkg::IDX_W-1:0]     queue_rdata,
   output hpa_pkg::map_port_type              map_port,
   input  wire logic                          map_rdata
);

   import hpa_pkg::*;

   state_type           state_ff, state_in;
   logic [IDX_W-1:0]    head_ff, head_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [CNT_W-1:0]    fresh_ff, fresh_in;
   op_type              op_ff, op_in;
   logic [HANDLE_W-1:0] hin_ff, hin_in;

   logic [SUM_W-1:0]    tail_sum;
   logic [IDX_W-1:0]    tail_idx;
   logic [IDX_W-1:0]    head_next;
   logic                queue_empty;
   logic                fresh_left;
   logic                allocated;

   assign queue_empty = (count_ff == '0);
   assign fresh_left  = (fresh_ff < CNT_W'(POOL_SIZE));
   assign allocated   = (CMP_W'(hin_ff) < CMP_W'(fresh_ff)) && map_rdata;
   assign tail_sum    = SUM_W'(head_ff) + SUM_W'(count_ff);
   assign tail_idx    = (tail_sum >= SUM_W'(POOL_SIZE)) ?
                        IDX_W'(tail_sum - SUM_W'(POOL_SIZE)) : IDX_W'(tail_sum);
   assign head_next   = (CNT_W'(head_ff) == CNT_W'(POOL_SIZE - 1)) ?
                        '0 : IDX_W'(CNT_W'(head_ff) + CNT_W'(1));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         head_ff  <= '0;
         count_ff <= '0;
         fresh_ff <= '0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         count_ff <= count_in;
         fresh_ff <= fresh_in;
      end
      op_ff  <= op_in;
      hin_ff <= hin_in;
   end

   always_comb begin
      state_in           = state_ff;
      head_in            = head_ff;
      count_in           = count_ff;
      fresh_in           = fresh_ff;
      op_in              = op_ff;
      hin_in             = hin_ff;
      req_ready          = 1'b0;
      rsp_load           = 1'b0;
      rsp_result.handle  = '0;
      rsp_result.status  = STAT_OK;
      queue_port.rd_en   = 1'b0;
      queue_port.rd_addr = head_ff;
      queue_port.wr_en   = 1'b0;
      queue_port.wr_addr = tail_idx;
      queue_port.wr_data = IDX_W'(hin_ff);
      map_port.rd_en     = 1'b0;
      map_port.rd_addr   = IDX_W'(req_handle);
      map_port.wr_en     = 1'b0;
      map_port.wr_addr   = IDX_W'(hin_ff);
      map_port.wr_data   = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               queue_port.rd_en = 1'b1;
               map_port.rd_en   = 1'b1;
               op_in            = req_op;
               hin_in           = req_handle;
               state_in         = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (out_free) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
               case (op_ff)
                  OP_ALLOC, OP_TRY: begin
                     if (!queue_empty) begin
                        rsp_result.handle = HANDLE_W'(queue_rdata);
                        map_port.wr_en    = 1'b1;
                        map_port.wr_addr  = queue_rdata;
                        map_port.wr_data  = 1'b1;
                        head_in           = head_next;
                        count_in          = count_ff - CNT_W'(1);
                     end else if (op_ff == OP_TRY) begin
                        rsp_result.status = STAT_EMPTY;
                     end else if (fresh_left) begin
                        rsp_result.handle = HANDLE_W'(fresh_ff);
                        map_port.wr_en    = 1'b1;
                        map_port.wr_addr  = IDX_W'(fresh_ff);
                        map_port.wr_data  = 1'b1;
                        fresh_in          = fresh_ff + CNT_W'(1);
                     end else begin
                        rsp_result.status = STAT_EXHAUSTED;
                     end
                  end
                  OP_FREE: begin
                     if (allocated) begin
                        map_port.wr_en   = 1'b1;
                        queue_port.wr_en = 1'b1;
                        count_in         = count_ff + CNT_W'(1);
                     end else begin
                        rsp_result.status = STAT_NOT_ALLOC;
                     end
                  end
                  default: begin
                     rsp_result.status = STAT_OK;
                  end
               endcase
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== rtl/handle_pool_allocator.sv =====
// Top level of the handle pool allocator: memories, sequencer and result register.
//
// Each request is taken in ST_IDLE, which reads the released-handle queue and the
// allocation map, and ends in ST_EXEC, which waits for a free output register, uses
// the registered read data and updates the counters and both memories. The result
// then sits in an output register, so the next request is taken while the previous
// result waits. Map entries at or above the count of handles ever handed out read
// as not allocated, so the map needs no clearing after reset.
`default_nettype none

module handle_pool_allocator
(
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   input  wire logic [hpa_pkg::HANDLE_W-1:0]  req_tdata,  // [7:0] handle_in
   input  wire logic [1:0]                    req_tuser,  // [1:0] op
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   output logic      [hpa_pkg::HANDLE_W-1:0]  rsp_tdata,  // [7:0] handle_out
   output logic      [1:0]                    rsp_tuser   // [1:0] status
);

   import hpa_pkg::*;

   queue_port_type   queue_port;
   map_port_type     map_port;
   logic [IDX_W-1:0] queue_rdata;
   logic             map_rdata;
   logic             rsp_load;
   result_type       rsp_result;
   logic             out_free;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [HANDLE_W-1:0] rsp_data_ff, rsp_data_in;
   logic [1:0]          rsp_user_ff, rsp_user_in;

   hpa_ram #(
      .WIDTH (IDX_W),
      .DEPTH (POOL_SIZE)
   ) u_queue_ram (
      .clock   (clock),
      .wr_en   (queue_port.wr_en),
      .wr_addr (queue_port.wr_addr),
      .wr_data (queue_port.wr_data),
      .rd_en   (queue_port.rd_en),
      .rd_addr (queue_port.rd_addr),
      .rd_data (queue_rdata)
   );

   hpa_ram #(
      .WIDTH (1),
      .DEPTH (POOL_SIZE)
   ) u_map_ram (
      .clock   (clock),
      .wr_en   (map_port.wr_en),
      .wr_addr (map_port.wr_addr),
      .wr_data (map_port.wr_data),
      .rd_en   (map_port.rd_en),
      .rd_addr (map_port.rd_addr),
      .rd_data (map_rdata)
   );

   hpa_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req_op      (op_type'(req_tuser)),
      .req_handle  (req_tdata),
      .out_free    (out_free),
      .rsp_load    (rsp_load),
      .rsp_result  (rsp_result),
      .queue_port  (queue_port),
      .queue_rdata (queue_rdata),
      .map_port    (map_port),
      .map_rdata   (map_rdata)
   );

   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_tready);
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      if (rsp_load) begin
         rsp_data_in = rsp_result.handle;
         rsp_user_in = 2'(rsp_result.status);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

`default_nettype wire
